// ===== src/qrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared constants, codes and types of the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

    // scale word is SCALE_CHUNKS component widths wide
    localparam int unsigned SCALE_CHUNKS = 4;
    // latency of one chunked multiplier, and of the rounding tail of the divider
    localparam int unsigned MUL_LAT      = 2;
    localparam int unsigned RECIP_TAIL   = 1;

    localparam int unsigned NUM_COMP = 4;
    localparam int unsigned C_X = 0;
    localparam int unsigned C_Y = 1;
    localparam int unsigned C_Z = 2;
    localparam int unsigned C_W = 3;

    localparam int unsigned NUM_TERMS = 9;
    localparam int unsigned T_XX = 0;
    localparam int unsigned T_XY = 1;
    localparam int unsigned T_XZ = 2;
    localparam int unsigned T_YY = 3;
    localparam int unsigned T_YZ = 4;
    localparam int unsigned T_ZZ = 5;
    localparam int unsigned T_WX = 6;
    localparam int unsigned T_WY = 7;
    localparam int unsigned T_WZ = 8;

    typedef struct packed {
        logic                zero;
        logic [NUM_COMP-1:0] sgn;
    } flags_t;

    // first factor of a product term
    function automatic int unsigned term_a(input int unsigned k);
        int unsigned r;
        unique case (k) inside
            T_XX, T_XY, T_XZ: r = C_X;
            T_YY, T_YZ:       r = C_Y;
            T_ZZ:             r = C_Z;
            T_WX, T_WY, T_WZ: r = C_W;
            default:          r = C_X;
        endcase
        return r;
    endfunction

    // second factor of a product term
    function automatic int unsigned term_b(input int unsigned k);
        int unsigned r;
        unique case (k) inside
            T_XX, T_WX:             r = C_X;
            T_XY, T_YY, T_WY:       r = C_Y;
            T_XZ, T_YZ, T_ZZ, T_WZ: r = C_Z;
            default:                r = C_Z;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/qrm_mulw.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrm_mulw
// Unsigned W x (CHUNKS*W) multiplier: one W x W partial product per chunk,
// then one add of the even and odd partial rows. Two register stages.
// ----------------------------------------------------------------------------
module qrm_mulw #(
    parameter int unsigned COMP_WIDTH = 16,
    parameter int unsigned CHUNKS     = 4
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic [COMP_WIDTH-1:0]              a,
    input  logic [CHUNKS*COMP_WIDTH-1:0]       b,
    output logic [(CHUNKS+1)*COMP_WIDTH-1:0]   p
);

    localparam int unsigned W  = COMP_WIDTH;
    localparam int unsigned PW = (CHUNKS + 1) * W;

    logic [2*W-1:0] pp_reg [CHUNKS];
    logic [PW-1:0]  even_row;
    logic [PW-1:0]  odd_row;
    logic [PW-1:0]  p_reg;

    // even and odd partials do not overlap within their row
    always_comb
    begin
        even_row = '0;
        odd_row  = '0;
        for (int k = 0; k < int'(CHUNKS); k++)
        begin
            if (k % 2 == 0)
            begin
                even_row[k*W +: 2*W] = pp_reg[k];
            end
            else
            begin
                odd_row[k*W +: 2*W] = pp_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < int'(CHUNKS); k++)
            begin
                pp_reg[k] <= (2*W)'(a) * (2*W)'(b[k*W +: W]);
            end
            p_reg <= even_row + odd_row;
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== src/qrm_recip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrm_recip
// Pipelined restoring divider: scale = round(2^(4W-1) / norm), ties up,
// zero for a zero norm. One quotient bit per stage plus a rounding stage.
// ----------------------------------------------------------------------------
module qrm_recip
    import qrm_pkg::*;
#(
    parameter int unsigned COMP_WIDTH = 16,
    parameter int unsigned SIDE_WIDTH = 1
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [2*COMP_WIDTH:0]                norm,
    input  logic [SIDE_WIDTH-1:0]                side_in,
    output logic [SCALE_CHUNKS*COMP_WIDTH-1:0]   scale,
    output logic [SIDE_WIDTH-1:0]                side_out
);

    localparam int unsigned W  = COMP_WIDTH;
    localparam int unsigned QW = SCALE_CHUNKS * W;
    localparam int unsigned RW = 2 * W + 1;

    logic [RW-1:0]         r_reg    [QW];
    logic [QW-1:0]         q_reg    [QW];
    logic [RW-1:0]         n_reg    [QW];
    logic [SIDE_WIDTH-1:0] side_reg [QW];

    logic [QW-1:0]         scale_reg;
    logic [QW-1:0]         scale_next;
    logic [SIDE_WIDTH-1:0] side_out_reg;
    logic                  rnd;

    for (genvar i = 0; i < int'(QW); i++)
    begin : g_bit
        logic [RW-1:0]         r_cur;
        logic [RW-1:0]         n_cur;
        logic [QW-1:0]         q_cur;
        logic [SIDE_WIDTH-1:0] side_cur;
        logic [RW:0]           shifted;
        logic [RW:0]           diff;
        logic                  ge;

        if (i == 0)
        begin : g_head
            assign r_cur    = '0;
            assign q_cur    = '0;
            assign n_cur    = norm;
            assign side_cur = side_in;
        end
        else
        begin : g_tail
            assign r_cur    = r_reg[i-1];
            assign q_cur    = q_reg[i-1];
            assign n_cur    = n_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        // dividend is a single one at its top bit
        assign shifted = {r_cur, 1'(i == 0)};
        assign ge      = shifted >= {1'b0, n_cur};
        assign diff    = shifted - {1'b0, n_cur};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]    <= ge ? diff[RW-1:0] : shifted[RW-1:0];
                q_reg[i]    <= {q_cur[QW-2:0], ge};
                n_reg[i]    <= n_cur;
                side_reg[i] <= side_cur;
            end
        end
    end

    always_comb
    begin
        rnd = {r_reg[QW-1], 1'b0} >= {1'b0, n_reg[QW-1]};
        if (n_reg[QW-1] == '0)
        begin
            scale_next = '0;
        end
        else
        begin
            scale_next = q_reg[QW-1] + QW'(rnd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scale_reg    <= scale_next;
            side_out_reg <= side_reg[QW-1];
        end
    end

    assign scale    = scale_reg;
    assign side_out = side_out_reg;

endmodule
`default_nettype wire

// ===== src/quaternion_to_rotation_matrix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Quaternion (Q2.14) to 3x3 rotation matrix (Q2.14, saturated).
//
//   channel   dir  payload
//   s_axis    in   tdata: qx, qy, qz, qw (COMP_WIDTH each)
//   m_axis    out  tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22; tuser: zero_norm
//
// One item per cycle while the spare output slot is empty. Most of the
// pipeline depth is the one-bit-per-stage reciprocal divider. Reset clears
// the valid bits only.
// The pipeline freezes only while the spare output slot is occupied, so an
// item is accepted while a finished one waits at the output.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
#(
    parameter int unsigned COMP_WIDTH = 16
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             s_axis_tvalid,
    output logic                                             s_axis_tready,
    // qx, qy, qz, qw
    input  logic [((NUM_COMP*COMP_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                             m_axis_tvalid,
    input  logic                                             m_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic [((NUM_TERMS*COMP_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // zero_norm
    output logic                                             m_axis_tuser
);

    localparam int unsigned W         = COMP_WIDTH;
    localparam int unsigned QW        = SCALE_CHUNKS * W;
    localparam int unsigned UW        = QW + W;
    localparam int unsigned PW        = UW + W;
    localparam int unsigned RW        = 2 * W + 1;
    localparam int unsigned TW        = W + 3;
    localparam int unsigned EW        = W + 4;
    localparam int unsigned OUT_DW    = ((NUM_TERMS * W + 7) / 8) * 8;
    localparam int unsigned SIDE_W    = NUM_COMP * W + NUM_COMP;
    localparam int unsigned RECIP_LAT = QW + RECIP_TAIL;

    localparam int unsigned ST_N = 2;
    localparam int unsigned ST_S = ST_N + RECIP_LAT;
    localparam int unsigned ST_U = ST_S + MUL_LAT;
    localparam int unsigned ST_P = ST_U + MUL_LAT;
    localparam int unsigned ST_T = ST_P + 1;
    localparam int unsigned ST_E = ST_T + 1;
    localparam int unsigned LAT  = ST_E + 1;

    localparam logic signed [EW-1:0] ONE_E = EW'(2 ** (W - 2));
    localparam logic [W-1:0]         ONE_W = W'(2 ** (W - 2));

    logic                           adv;
    logic [LAT-1:0]                 v_reg;

    logic [NUM_COMP-1:0][W-1:0]     q_reg;
    logic signed [2*W-1:0]          sq_s     [NUM_COMP];
    logic [2*W-1:0]                 sq_next  [NUM_COMP];
    logic [NUM_COMP-1:0][W-1:0]     mag_next;
    logic [2*W-1:0]                 sq_reg   [NUM_COMP];
    logic [NUM_COMP-1:0][W-1:0]     mag1_reg;
    logic [NUM_COMP-1:0]            sgn1_reg;

    logic [RW-1:0]                  n_next;
    logic [RW-1:0]                  n_reg;
    logic [NUM_COMP-1:0][W-1:0]     mag2_reg;
    logic [NUM_COMP-1:0]            sgn2_reg;

    logic [SIDE_W-1:0]              side_s;
    logic [QW-1:0]                  scale;
    logic [NUM_COMP-1:0][W-1:0]     mag_s;
    flags_t                         flags_s;

    logic [NUM_COMP-1:0][W-1:0]     mag_dly_reg  [MUL_LAT];
    flags_t                         flag_dly_reg [2*MUL_LAT];
    flags_t                         flags_p;

    logic [UW-1:0]                  u_prod [NUM_COMP];
    logic [PW-1:0]                  p_term [NUM_TERMS];

    logic [W+1:0]                   t_mag    [NUM_TERMS];
    logic signed [TW-1:0]           t_pos    [NUM_TERMS];
    logic signed [TW-1:0]           t_next   [NUM_TERMS];
    logic signed [TW-1:0]           t_reg    [NUM_TERMS];
    logic                           t_zero_reg;

    logic signed [EW-1:0]           e        [NUM_TERMS];
    logic [NUM_TERMS-1:0][W-1:0]    ent_next;
    logic [NUM_TERMS-1:0][W-1:0]    ent_reg;
    logic                           ent_zero_reg;

    logic                           skid_in;
    logic                           out_take;
    logic                           out_valid_reg;
    logic                           spare_valid_reg;
    logic [NUM_TERMS-1:0][W-1:0]    out_m_reg;
    logic                           out_zero_reg;
    logic [NUM_TERMS-1:0][W-1:0]    spare_m_reg;
    logic                           spare_zero_reg;

    function automatic logic [W-1:0] sat(input logic signed [EW-1:0] v);
        logic [W-1:0] r;
        if (v[EW-1:W-1] == '0 || v[EW-1:W-1] == '1)
        begin
            r = v[W-1:0];
        end
        else if (v[EW-1])
        begin
            r = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    assign adv           = ~spare_valid_reg;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // squares and magnitudes
    always_comb
    begin
        for (int c = 0; c < int'(NUM_COMP); c++)
        begin
            sq_s[c]     = (2*W)'($signed(q_reg[c])) * (2*W)'($signed(q_reg[c]));
            sq_next[c]  = $unsigned(sq_s[c]);
            mag_next[c] = q_reg[c][W-1] ? (-q_reg[c]) : q_reg[c];
        end
    end

    always_comb
    begin
        n_next = RW'(sq_reg[C_X]) + RW'(sq_reg[C_Y]) + RW'(sq_reg[C_Z]) + RW'(sq_reg[C_W]);
    end

    qrm_recip #(
        .COMP_WIDTH (W),
        .SIDE_WIDTH (SIDE_W)
    ) u_recip (
        .clk      (clk),
        .en       (adv),
        .norm     (n_reg),
        .side_in  ({sgn2_reg, mag2_reg}),
        .scale    (scale),
        .side_out (side_s)
    );

    assign mag_s        = side_s[NUM_COMP*W-1:0];
    assign flags_s.sgn  = side_s[SIDE_W-1 -: NUM_COMP];
    assign flags_s.zero = (scale == '0);
    assign flags_p      = flag_dly_reg[2*MUL_LAT-1];

    // |b| * s for each component
    for (genvar c = 0; c < int'(NUM_COMP); c++)
    begin : g_scale_mul
        qrm_mulw #(
            .COMP_WIDTH (W),
            .CHUNKS     (SCALE_CHUNKS)
        ) u_mul (
            .clk (clk),
            .en  (adv),
            .a   (mag_s[c]),
            .b   (scale),
            .p   (u_prod[c])
        );
    end

    // |a| * |b| * s for each term
    for (genvar k = 0; k < int'(NUM_TERMS); k++)
    begin : g_term_mul
        localparam int unsigned KA = term_a(k);
        localparam int unsigned KB = term_b(k);

        qrm_mulw #(
            .COMP_WIDTH (W),
            .CHUNKS     (SCALE_CHUNKS + 1)
        ) u_mul (
            .clk (clk),
            .en  (adv),
            .a   (mag_dly_reg[MUL_LAT-1][KA]),
            .b   (u_prod[KB]),
            .p   (p_term[k])
        );
    end

    // round half away from zero on the magnitude, then apply the sign
    always_comb
    begin
        for (int k = 0; k < int'(NUM_TERMS); k++)
        begin
            t_mag[k]  = p_term[k][3*W +: W+2] + (W+2)'(p_term[k][3*W-1]);
            t_pos[k]  = signed'({1'b0, t_mag[k]});
            t_next[k] = (flags_p.sgn[term_a(k)] ^ flags_p.sgn[term_b(k)]) ? -t_pos[k]
                                                                           : t_pos[k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < int'(NUM_TERMS); k++)
        begin
            e[k] = EW'(t_reg[k]);
        end
        ent_next[0] = sat(ONE_E - (e[T_YY] + e[T_ZZ]));
        ent_next[1] = sat(e[T_XY] - e[T_WZ]);
        ent_next[2] = sat(e[T_XZ] + e[T_WY]);
        ent_next[3] = sat(e[T_XY] + e[T_WZ]);
        ent_next[4] = sat(ONE_E - (e[T_XX] + e[T_ZZ]));
        ent_next[5] = sat(e[T_YZ] - e[T_WX]);
        ent_next[6] = sat(e[T_XZ] - e[T_WY]);
        ent_next[7] = sat(e[T_YZ] + e[T_WX]);
        ent_next[8] = sat(ONE_E - (e[T_XX] + e[T_YY]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg <= s_axis_tdata[NUM_COMP*W-1:0];

            for (int c = 0; c < int'(NUM_COMP); c++)
            begin
                sq_reg[c]   <= sq_next[c];
                sgn1_reg[c] <= q_reg[c][W-1];
            end
            mag1_reg <= mag_next;

            n_reg    <= n_next;
            mag2_reg <= mag1_reg;
            sgn2_reg <= sgn1_reg;

            mag_dly_reg[0]  <= mag_s;
            flag_dly_reg[0] <= flags_s;
            for (int k = 1; k < int'(MUL_LAT); k++)
            begin
                mag_dly_reg[k] <= mag_dly_reg[k-1];
            end
            for (int k = 1; k < int'(2*MUL_LAT); k++)
            begin
                flag_dly_reg[k] <= flag_dly_reg[k-1];
            end

            for (int k = 0; k < int'(NUM_TERMS); k++)
            begin
                t_reg[k] <= t_next[k];
            end
            t_zero_reg <= flags_p.zero;

            ent_reg      <= ent_next;
            ent_zero_reg <= t_zero_reg;
        end
    end

    // output register with one spare slot
    assign skid_in  = adv & v_reg[ST_E];
    assign out_take = out_valid_reg & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_take)
        begin
            if (spare_valid_reg)
            begin
                out_valid_reg   <= 1'b1;
                spare_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= skid_in;
            end
        end
        else if (skid_in)
        begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_take)
        begin
            if (spare_valid_reg)
            begin
                out_m_reg    <= spare_m_reg;
                out_zero_reg <= spare_zero_reg;
            end
            else
            begin
                out_m_reg    <= ent_reg;
                out_zero_reg <= ent_zero_reg;
            end
        end
        else if (skid_in)
        begin
            spare_m_reg    <= ent_reg;
            spare_zero_reg <= ent_zero_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'(out_m_reg);
    assign m_axis_tuser  = out_zero_reg;

    a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        spare_valid_reg |-> out_valid_reg)
        else $error("spare slot filled while output empty");

    a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg))
        else $error("pipeline moved during stall");

    a_squares_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_T] |-> (!t_reg[T_XX][TW-1] && !t_reg[T_YY][TW-1] && !t_reg[T_ZZ][TW-1]))
        else $error("negative square term");

    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_zero_reg) |->
            (out_m_reg[0] == ONE_W && out_m_reg[4] == ONE_W && out_m_reg[8] == ONE_W &&
             out_m_reg[1] == '0 && out_m_reg[2] == '0 && out_m_reg[3] == '0 &&
             out_m_reg[5] == '0 && out_m_reg[6] == '0 && out_m_reg[7] == '0))
        else $error("zero norm item is not the identity");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quaternion_to_rotation_matrix.
//
// Items go in on the slave stream and matrices come out on the master stream.
// A bit-accurate predictor computes each matrix when its quaternion is
// accepted. The checker compares every output matrix, entry by entry and the
// zero-norm flag, against the oldest prediction. Both stream sides idle at
// random. One phase holds the output off long enough to back the block up and
// stall its input. Another phase streams with no idle cycles.
// ----------------------------------------------------------------------------
module testbench;
    import qrm_pkg::*;

    localparam int CW          = 16;
    localparam int DIN_W       = ((NUM_COMP*CW+7)/8)*8;
    localparam int DOUT_W      = ((NUM_TERMS*CW+7)/8)*8;
    localparam int NUM_ENTRIES = 9;
    localparam int LATENCY     = 4*CW+10;
    localparam int DRAIN_WAIT  = LATENCY+20;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTS  = 40;
    localparam int IDLE_PCT    = 31;

    localparam int M00 = 0;
    localparam int M01 = 1;
    localparam int M02 = 2;
    localparam int M10 = 3;
    localparam int M11 = 4;
    localparam int M12 = 5;
    localparam int M20 = 6;
    localparam int M21 = 7;
    localparam int M22 = 8;

    localparam logic signed [CW-1:0] ONE_Q  = CW'(1 << (CW-2));
    localparam logic signed [CW-1:0] HALF_Q = CW'(1 << (CW-3));
    localparam logic signed [CW-1:0] HALF_R = CW'(11585);   // about 1/sqrt(2)
    localparam logic signed [CW-1:0] MAX_Q  = CW'((1 << (CW-1)) - 1);
    localparam logic signed [CW-1:0] MIN_Q  = CW'(-(1 << (CW-1)));
    localparam logic signed [CW-1:0] ZERO_Q = '0;

    // last field (qx) in the lowest bits
    typedef struct packed {
        logic signed [CW-1:0] qw;
        logic signed [CW-1:0] qz;
        logic signed [CW-1:0] qy;
        logic signed [CW-1:0] qx;
    } quat_t;

    typedef struct packed {
        logic                               zero_norm;
        logic [NUM_ENTRIES-1:0][CW-1:0]     m;
    } matrix_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // qx, qy, qz, qw
    logic [DIN_W-1:0]  s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    logic [DOUT_W-1:0] m_axis_tdata;
    // zero_norm
    logic              m_axis_tuser;

    matrix_t matrix_q [$];
    string   entry_name [NUM_ENTRIES] =
        '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

    int err_count     = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int zero_count    = 0;
    int cycle_count   = 0;
    int stall_cycles  = 0;
    int send_idle_pct = IDLE_PCT;
    int recv_idle_pct = IDLE_PCT;
    int hold_req      = 0;
    int hold_ack      = 0;
    int hold_left     = 0;

    quaternion_to_rotation_matrix #(
        .COMP_WIDTH(CW)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // round(|a*b| * scale / 2^(3W)), ties away from zero, then sign
    function automatic longint scaled_product(input longint a, input longint b,
                                              input logic [127:0] scale);
        longint       ma;
        longint       mb;
        longint       mt;
        logic [127:0] p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p  = 128'(ma * mb) * scale;
        mt = longint'(p >> (3*CW)) + longint'(p[3*CW-1]);
        return ((a < 0) != (b < 0)) ? -mt : mt;
    endfunction

    function automatic logic [CW-1:0] clamp_entry(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (CW-1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[CW-1:0];
    endfunction

    function automatic matrix_t predict_matrix(input quat_t q);
        longint       c [NUM_COMP];
        longint       p [NUM_TERMS];
        longint       e [NUM_ENTRIES];
        longint       one;
        logic [127:0] norm;
        logic [127:0] numer;
        logic [127:0] scale;
        matrix_t      r;
        int           i;
        c[C_X] = longint'(q.qx);
        c[C_Y] = longint'(q.qy);
        c[C_Z] = longint'(q.qz);
        c[C_W] = longint'(q.qw);
        one    = longint'(1) << (CW-2);
        norm   = '0;
        for (i = 0; i < NUM_COMP; i++)
            norm = norm + 128'(c[i] * c[i]);
        scale = '0;
        if (norm != '0)
        begin
            numer = 128'(1) << (4*CW-1);
            scale = numer / norm;
            if (((numer % norm) << 1) >= norm)
                scale = scale + 128'(1);
        end
        p[T_XX] = scaled_product(c[C_X], c[C_X], scale);
        p[T_XY] = scaled_product(c[C_X], c[C_Y], scale);
        p[T_XZ] = scaled_product(c[C_X], c[C_Z], scale);
        p[T_YY] = scaled_product(c[C_Y], c[C_Y], scale);
        p[T_YZ] = scaled_product(c[C_Y], c[C_Z], scale);
        p[T_ZZ] = scaled_product(c[C_Z], c[C_Z], scale);
        p[T_WX] = scaled_product(c[C_W], c[C_X], scale);
        p[T_WY] = scaled_product(c[C_W], c[C_Y], scale);
        p[T_WZ] = scaled_product(c[C_W], c[C_Z], scale);

        e[M00] = one - (p[T_YY] + p[T_ZZ]);
        e[M01] = p[T_XY] - p[T_WZ];
        e[M02] = p[T_XZ] + p[T_WY];
        e[M10] = p[T_XY] + p[T_WZ];
        e[M11] = one - (p[T_XX] + p[T_ZZ]);
        e[M12] = p[T_YZ] - p[T_WX];
        e[M20] = p[T_XZ] - p[T_WY];
        e[M21] = p[T_YZ] + p[T_WX];
        e[M22] = one - (p[T_XX] + p[T_YY]);
        for (i = 0; i < NUM_ENTRIES; i++)
            r.m[i] = clamp_entry(e[i]);
        r.zero_norm = (norm == '0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stream drivers and checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic send_quat(input quat_t q);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DIN_W'(q);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        matrix_q.push_back(predict_matrix(q));
        sent_count++;
    endtask

    // receiver: random idling plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        matrix_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (matrix_q.size() == 0)
                report_mismatch("matrix item arrived with none expected");
            else
            begin
                want = matrix_q.pop_front();
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (m_axis_tdata[i*CW +: CW] !== want.m[i])
                        report_mismatch($sformatf("item %0d %s: got %0d, want %0d",
                            checked_count, entry_name[i],
                            $signed(m_axis_tdata[i*CW +: CW]), $signed(want.m[i])));
                if (m_axis_tuser !== want.zero_norm)
                    report_mismatch($sformatf("item %0d zero_norm: got %b, want %b",
                        checked_count, m_axis_tuser, want.zero_norm));
                if (want.zero_norm)
                    zero_count++;
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (s_axis_tvalid && !s_axis_tready)
            stall_cycles++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d matrices outstanding",
                     cycle_count, matrix_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic quat_t make_quat(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y,
                                        input logic signed [CW-1:0] z,
                                        input logic signed [CW-1:0] w);
        quat_t q;
        q.qx = x;
        q.qy = y;
        q.qz = z;
        q.qw = w;
        return q;
    endfunction

    function automatic logic signed [CW-1:0] random_comp(input int mode);
        logic signed [CW-1:0] v;
        case (mode)
            0: v = CW'($urandom);
            1: v = CW'($signed($urandom_range(2*ONE_Q)) - ONE_Q);
            2: v = CW'($signed($urandom_range(8)) - 4);
            default:
                case ($urandom_range(6))
                    0: v = MIN_Q;
                    1: v = MAX_Q;
                    2: v = CW'(-1);
                    3: v = CW'(1);
                    4: v = ONE_Q;
                    5: v = -ONE_Q;
                    default: v = ZERO_Q;
                endcase
        endcase
        return v;
    endfunction

    function automatic quat_t random_quat();
        quat_t q;
        int    pick;
        int    mode;
        pick = int'($urandom_range(99));
        if (pick < 40)
            mode = 0;
        else if (pick < 65)
            mode = 1;
        else if (pick < 80)
            mode = 2;
        else
            mode = 3;
        q = make_quat(random_comp(mode), random_comp(mode),
                      random_comp(mode), random_comp(mode));
        // sometimes knock out components to hit axis-aligned cases
        if (pick >= 90)
        begin
            if ($urandom_range(1)) q.qx = '0;
            if ($urandom_range(1)) q.qy = '0;
            if ($urandom_range(1)) q.qz = '0;
            if ($urandom_range(1)) q.qw = '0;
        end
        return q;
    endfunction

    task automatic test_directed();
        send_quat(make_quat(ZERO_Q, ZERO_Q, ZERO_Q, ONE_Q));
        send_quat(make_quat(ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q));
        send_quat(make_quat(ONE_Q, ZERO_Q, ZERO_Q, ZERO_Q));
        send_quat(make_quat(ZERO_Q, ONE_Q, ZERO_Q, ZERO_Q));
        send_quat(make_quat(ZERO_Q, ZERO_Q, ONE_Q, ZERO_Q));
        send_quat(make_quat(ZERO_Q, ZERO_Q, ZERO_Q, -ONE_Q));
        send_quat(make_quat(HALF_R, ZERO_Q, ZERO_Q, HALF_R));
        send_quat(make_quat(ZERO_Q, HALF_R, ZERO_Q, HALF_R));
        send_quat(make_quat(ZERO_Q, ZERO_Q, HALF_R, -HALF_R));
        send_quat(make_quat(HALF_Q, HALF_Q, HALF_Q, HALF_Q));
        send_quat(make_quat(HALF_Q, HALF_Q, HALF_Q, -HALF_Q));
        send_quat(make_quat(CW'(1), ZERO_Q, ZERO_Q, ZERO_Q));
        send_quat(make_quat(ZERO_Q, ZERO_Q, ZERO_Q, CW'(-1)));
        send_quat(make_quat(CW'(1), CW'(1), CW'(1), CW'(1)));
        send_quat(make_quat(CW'(1), CW'(-1), ZERO_Q, ZERO_Q));
        send_quat(make_quat(CW'(-1), CW'(2), CW'(-3), CW'(4)));
        send_quat(make_quat(MIN_Q, MIN_Q, MIN_Q, MIN_Q));
        send_quat(make_quat(MAX_Q, MAX_Q, MAX_Q, MAX_Q));
        send_quat(make_quat(MIN_Q, MAX_Q, MIN_Q, MAX_Q));
        send_quat(make_quat(MAX_Q, ZERO_Q, ZERO_Q, ZERO_Q));
        send_quat(make_quat(MIN_Q, ZERO_Q, ZERO_Q, ZERO_Q));
        send_quat(make_quat(MAX_Q, CW'(1), ZERO_Q, ZERO_Q));
        send_quat(make_quat(ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q));
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_quat(random_quat());
    endtask

    // output held off while the input keeps offering: pipeline fills, input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_req++;
        repeat (150)
            send_quat(random_quat());
        send_idle_pct = IDLE_PCT;
    endtask

    task automatic test_steady_stream();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (150)
            send_quat(random_quat());
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(400);
        test_backpressure();
        test_steady_stream();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (matrix_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("%0d quaternions sent (axes, zero norm, extremes, random), %0d matrices checked",
                 sent_count, checked_count);
        $display("%0d zero-norm results, %0d input stall cycles, %0d mismatches",
                 zero_count, stall_cycles, err_count);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
